>>> src/tiep_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tiep_pkg: shared types and constants for the terminal input parser
// Modes, event kinds, named key codes and the front-to-back queue entry.
// ----------------------------------------------------------------------------
package tiep_pkg;

	localparam int MAX_PARAMS = 3;
	localparam int PARAM_BITS = 21;
	localparam int CODE_W     = 21;
	localparam int POS_W      = 22;
	localparam int QDEPTH     = 4;
	localparam int QPTR_W     = $clog2(QDEPTH);

	localparam logic [PARAM_BITS-1:0] PARAM_MAX = {PARAM_BITS{1'b1}};
	localparam logic [CODE_W-1:0]     CODE_MAX  = {CODE_W{1'b1}};
	localparam logic [7:0]            BYTE_ESC  = 8'h1b;
	localparam int                    PASTE_OPEN = 200;

	typedef enum logic [2:0] {
		MODE_NORMAL = 3'd0,
		MODE_ESCAPE = 3'd1,
		MODE_SS3    = 3'd2,
		MODE_CSI    = 3'd3,
		MODE_PASTE  = 3'd4
	} mode_t;

	typedef enum logic [2:0] {
		EV_CHAR      = 3'd0,
		EV_KEY       = 3'd1,
		EV_MOUSE     = 3'd2,
		EV_PASTE     = 3'd3,
		EV_PASTE_END = 3'd4
	} ev_kind_t;

	localparam logic [CODE_W-1:0] K_ENTER  = 21'd0;
	localparam logic [CODE_W-1:0] K_TAB    = 21'd1;
	localparam logic [CODE_W-1:0] K_BKSP   = 21'd2;
	localparam logic [CODE_W-1:0] K_ESC    = 21'd3;
	localparam logic [CODE_W-1:0] K_UP     = 21'd4;
	localparam logic [CODE_W-1:0] K_DOWN   = 21'd5;
	localparam logic [CODE_W-1:0] K_RIGHT  = 21'd6;
	localparam logic [CODE_W-1:0] K_LEFT   = 21'd7;
	localparam logic [CODE_W-1:0] K_HOME   = 21'd8;
	localparam logic [CODE_W-1:0] K_END    = 21'd9;
	localparam logic [CODE_W-1:0] K_INSERT = 21'd10;
	localparam logic [CODE_W-1:0] K_DELETE = 21'd11;
	localparam logic [CODE_W-1:0] K_PGUP   = 21'd12;
	localparam logic [CODE_W-1:0] K_PGDN   = 21'd13;
	localparam logic [CODE_W-1:0] K_F1     = 21'd14;

	// what the back end does with one queued item
	typedef enum logic [1:0] {
		ACT_NONE  = 2'd0,  // no event
		ACT_ONE   = 2'd1,  // one event from the entry fields
		ACT_ESC1  = 2'd2,  // Escape, then the entry event if has_ev
		ACT_PFX   = 2'd3   // terminator prefix bytes, then the entry event if has_ev
	} act_t;

	typedef struct packed {
		act_t              act;
		logic              has_ev;
		logic [2:0]        pfx_len;
		logic [2:0]        kind;
		logic [CODE_W-1:0] code;
		logic [2:0]        mods;
		logic [2:0]        mouse_kind;
		logic [1:0]        mouse_button;
		logic [POS_W-1:0]  col;
		logic [POS_W-1:0]  row;
	} qent_t;

	function automatic logic [7:0] term_byte(input logic [2:0] k);
		case (k)
			3'd0:    term_byte = 8'h1b;
			3'd1:    term_byte = 8'h5b;
			3'd2:    term_byte = 8'h32;
			3'd3:    term_byte = 8'h30;
			3'd4:    term_byte = 8'h31;
			3'd5:    term_byte = 8'h7e;
			default: term_byte = 8'h00;
		endcase
	endfunction

endpackage

>>> src/terminal_input_escape_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// terminal_input_escape_parser_unit: xterm-style terminal input decoder
// Turns raw terminal bytes into key, mouse and paste events.
// ----------------------------------------------------------------------------
// channel | dir | tdata (low bit first)                   | tuser      | tlast
// s_axis  | in  | in_byte[7:0]                            | op         | -
// m_axis  | out | code, mods, mouse_kind, mouse_button,   | event_kind | last
//         |     | col, row (73 bits, zero pad to 80)      |            |
//
// One input item per cycle. The front end classifies each item and queues
// one action; the back end emits the events of that action one after another
// (at most 6, none for some items) and stalls while m_axis is not ready, and
// the 4-entry queue throttles s_axis_tready only when it fills.
// arst_n clears mode, parameter and queue state; no clearing pass is needed.
// Output is a registered stage: the next item is taken while a result waits.
// ----------------------------------------------------------------------------
module terminal_input_escape_parser_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // in_byte[7:0]
	input  logic        s_axis_tuser,   // op
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [20:0] code, [23:21] mods, [26:24] mouse_kind, [28:27] mouse_button,
	// [50:29] col, [72:51] row, [79:73] zero
	output logic [79:0] m_axis_tdata,
	output logic [2:0]  m_axis_tuser,   // [2:0] event_kind
	output logic        m_axis_tlast
);

	logic            q_push, q_full, q_pop, q_ne;
	tiep_pkg::qent_t q_w, q_r;
	logic [2:0]      o_mods, o_mkind;
	logic [1:0]      o_btn;
	logic [tiep_pkg::CODE_W-1:0] o_code;
	logic [tiep_pkg::POS_W-1:0]  o_col, o_row;

	tiep_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_op    (s_axis_tuser),
		.in_byte  (s_axis_tdata),
		.q_push   (q_push),
		.q_data   (q_w),
		.q_full   (q_full)
	);

	tiep_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.wdata     (q_w),
		.full      (q_full),
		.pop       (q_pop),
		.rdata     (q_r),
		.not_empty (q_ne)
	);

	tiep_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_ne),
		.q_data    (q_r),
		.q_pop     (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_kind  (m_axis_tuser),
		.out_code  (o_code),
		.out_mods  (o_mods),
		.out_mkind (o_mkind),
		.out_btn   (o_btn),
		.out_col   (o_col),
		.out_row   (o_row),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {7'd0, o_row, o_col, o_btn, o_mkind, o_mods, o_code};

endmodule

>>> src/tiep_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tiep_front: byte classifier and sequence state
// Tracks escape/CSI/paste state, one byte a cycle unless the queue is full, and queues one action.
// ----------------------------------------------------------------------------
module tiep_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                in_op,
	input  logic [7:0]          in_byte,
	output logic                q_push,
	output tiep_pkg::qent_t     q_data,
	input  logic                q_full
);

	localparam int PB = tiep_pkg::PARAM_BITS;
	localparam int CW = tiep_pkg::CODE_W;
	localparam int PW = tiep_pkg::POS_W;
	localparam int NP = tiep_pkg::MAX_PARAMS;
	localparam int CNT_W = $clog2(NP + 1);

	tiep_pkg::mode_t   mode_q, mode_d;
	logic [PB-1:0]     pval_q [NP];
	logic [NP-1:0]     pvld_q;
	logic [CNT_W-1:0]  pcnt_q;
	logic [PB-1:0]     cur_q;
	logic              cur_vld_q;
	logic              sub_q;
	logic              mouse_q;
	logic [2:0]        tmatch_q;

	logic              fire;
	tiep_pkg::qent_t   ent;
	logic [PB-1:0]     p_val [NP];
	logic [NP-1:0]     p_vld;
	logic [PB+3:0]     acc;
	logic [PB-1:0]     acc_sat;
	logic              is_digit, is_final;

	assign in_ready = !q_full;
	assign fire     = in_valid && in_ready;
	assign q_push   = fire;
	assign q_data   = ent;

	assign is_digit = (in_byte >= 8'h30) && (in_byte <= 8'h39);
	assign is_final = !is_digit && (in_byte != 8'h3a) && (in_byte != 8'h3b)
		&& !(in_byte == 8'h3c && pcnt_q == '0 && !cur_vld_q && !sub_q);
	assign acc = (cur_vld_q ? ({4'd0, cur_q} * (PB+4)'(10)) : '0)
		+ (PB+4)'(in_byte - 8'h30);
	assign acc_sat = (acc > (PB+4)'(tiep_pkg::PARAM_MAX)) ? tiep_pkg::PARAM_MAX
		: acc[PB-1:0];

	// parameter view after pushing the current one (used on a final byte)
	always_comb begin
		for (int i = 0; i < NP; i++) begin
			if (i < int'(pcnt_q)) begin
				p_val[i] = pval_q[i];
				p_vld[i] = pvld_q[i];
			end else if (i == int'(pcnt_q)) begin
				p_val[i] = cur_q;
				p_vld[i] = cur_vld_q;
			end else begin
				p_val[i] = '0;
				p_vld[i] = 1'b0;
			end
		end
	end

	function automatic logic [CW-1:0] sat_code(input logic [PB-1:0] v);
		if ((PB+1)'(v) > (PB+1)'(tiep_pkg::CODE_MAX)) sat_code = tiep_pkg::CODE_MAX;
		else sat_code = CW'(v);
	endfunction

	function automatic void clear_ev(output tiep_pkg::qent_t e);
		e = '0;
		e.act = tiep_pkg::ACT_NONE;
	endfunction

	// normal-mode byte decode: returns has_ev and fields
	function automatic logic norm_ev(input logic [7:0] b, output logic [2:0] k,
			output logic [CW-1:0] c);
		norm_ev = 1'b1;
		k = tiep_pkg::EV_KEY;
		c = '0;
		if (b == 8'h0a) c = tiep_pkg::K_ENTER;
		else if (b == 8'h09) c = tiep_pkg::K_TAB;
		else if (b == 8'h7f) c = tiep_pkg::K_BKSP;
		else if (b >= 8'h20 && b <= 8'h7e) begin
			k = tiep_pkg::EV_CHAR;
			c = CW'(b);
		end else norm_ev = 1'b0;
	endfunction

	always_comb begin
		logic [2:0]    m, mods;
		logic [PB-1:0] p0, p1;
		logic [2:0]    nk;
		logic [CW-1:0] nc;
		logic          ne;
		logic [1:0]    low;
		clear_ev(ent);
		mode_d = mode_q;
		m = '0; mods = '0; p0 = '0; p1 = '0; nk = '0; nc = '0; ne = 1'b0; low = '0;
		if (in_op) begin
			if (mode_q == tiep_pkg::MODE_ESCAPE || mode_q == tiep_pkg::MODE_SS3) begin
				ent.act = tiep_pkg::ACT_ONE;
				ent.kind = tiep_pkg::EV_KEY;
				ent.code = tiep_pkg::K_ESC;
			end
			mode_d = tiep_pkg::MODE_NORMAL;
		end else begin
			case (mode_q)
				tiep_pkg::MODE_ESCAPE: begin
					mode_d = tiep_pkg::MODE_NORMAL;
					if (in_byte == 8'h5b) mode_d = tiep_pkg::MODE_CSI;
					else if (in_byte == 8'h4f) mode_d = tiep_pkg::MODE_SS3;
					else if (in_byte == tiep_pkg::BYTE_ESC) begin
						ent.act = tiep_pkg::ACT_ONE;
						ent.kind = tiep_pkg::EV_KEY;
						ent.code = tiep_pkg::K_ESC;
						mode_d = tiep_pkg::MODE_ESCAPE;
					end else begin
						ne = norm_ev(in_byte, nk, nc);
						ent.act = tiep_pkg::ACT_ESC1;
						ent.has_ev = ne;
						ent.kind = nk;
						ent.code = nc;
					end
				end
				tiep_pkg::MODE_SS3: begin
					mode_d = tiep_pkg::MODE_NORMAL;
					if (in_byte >= 8'h50 && in_byte <= 8'h53) begin
						ent.act = tiep_pkg::ACT_ONE;
						ent.kind = tiep_pkg::EV_KEY;
						ent.code = tiep_pkg::K_F1 + CW'(in_byte - 8'h50);
					end
				end
				tiep_pkg::MODE_CSI: begin
					if (is_final) begin
						mode_d = tiep_pkg::MODE_NORMAL;
						p0 = p_vld[0] ? p_val[0] : '0;
						if (in_byte == 8'h7e && !mouse_q && p_vld[0]
								&& p_val[0] == PB'(tiep_pkg::PASTE_OPEN)) begin
							mode_d = tiep_pkg::MODE_PASTE;
						end else if (mouse_q) begin
							if ((in_byte == 8'h4d || in_byte == 8'h6d)
									&& p_vld[0] && p_vld[1] && p_vld[2]) begin
								ent.act = tiep_pkg::ACT_ONE;
								ent.kind = tiep_pkg::EV_MOUSE;
								ent.mods = {p_val[0][4], p_val[0][3], p_val[0][2]};
								low = p_val[0][1:0];
								if (p_val[0][6]) begin
									ent.mouse_kind = (low == 2'd0) ? 3'd3 : 3'd4;
									ent.mouse_button = 2'd0;
								end else begin
									ent.mouse_button = (low == 2'd3) ? 2'd0 : low + 2'd1;
									ent.mouse_kind = p_val[0][5] ? 3'd2
										: (in_byte == 8'h4d ? 3'd0 : 3'd1);
								end
								ent.col = PW'(sat_code(p_val[1])) - PW'(1);
								ent.row = PW'(sat_code(p_val[2])) - PW'(1);
							end
						end else begin
							p1 = p_vld[1] ? p_val[1] : PB'(1);
							mods = (p1 >= PB'(1)) ? 3'(p1 - PB'(1)) : 3'd0;
							ent.kind = tiep_pkg::EV_KEY;
							ent.mods = mods;
							ent.act = tiep_pkg::ACT_ONE;
							case (in_byte)
								8'h41: ent.code = tiep_pkg::K_UP;
								8'h42: ent.code = tiep_pkg::K_DOWN;
								8'h43: ent.code = tiep_pkg::K_RIGHT;
								8'h44: ent.code = tiep_pkg::K_LEFT;
								8'h48: ent.code = tiep_pkg::K_HOME;
								8'h46: ent.code = tiep_pkg::K_END;
								8'h7e: begin
									case (p0)
										PB'(2):  ent.code = tiep_pkg::K_INSERT;
										PB'(3):  ent.code = tiep_pkg::K_DELETE;
										PB'(4), PB'(8): ent.code = tiep_pkg::K_END;
										PB'(5):  ent.code = tiep_pkg::K_PGUP;
										PB'(6):  ent.code = tiep_pkg::K_PGDN;
										PB'(7):  ent.code = tiep_pkg::K_HOME;
										PB'(11), PB'(12), PB'(13), PB'(14), PB'(15):
											ent.code = tiep_pkg::K_F1 + CW'(p0 - PB'(11));
										PB'(17), PB'(18), PB'(19), PB'(20), PB'(21):
											ent.code = tiep_pkg::K_F1 + CW'(5)
												+ CW'(p0 - PB'(17));
										PB'(23), PB'(24):
											ent.code = tiep_pkg::K_F1 + CW'(10)
												+ CW'(p0 - PB'(23));
										default: ent.act = tiep_pkg::ACT_NONE;
									endcase
								end
								8'h75: begin
									if (!p_vld[0]) ent.act = tiep_pkg::ACT_NONE;
									else if (p_val[0] == PB'(9)) ent.code = tiep_pkg::K_TAB;
									else if (p_val[0] == PB'(13)) ent.code = tiep_pkg::K_ENTER;
									else if (p_val[0] == PB'(27)) ent.code = tiep_pkg::K_ESC;
									else if (p_val[0] == PB'(127)) ent.code = tiep_pkg::K_BKSP;
									else begin
										ent.kind = tiep_pkg::EV_CHAR;
										ent.code = sat_code(p_val[0]);
									end
								end
								default: ent.act = tiep_pkg::ACT_NONE;
							endcase
						end
					end
				end
				tiep_pkg::MODE_PASTE: begin
					m = (tmatch_q < 3'd6) ? tmatch_q : 3'd0;
					if (in_byte == tiep_pkg::term_byte(m)) begin
						if (m == 3'd5) begin
							mode_d = tiep_pkg::MODE_NORMAL;
							ent.act = tiep_pkg::ACT_ONE;
							ent.kind = tiep_pkg::EV_PASTE_END;
						end
					end else begin
						ent.kind = tiep_pkg::EV_PASTE;
						ent.code = CW'(in_byte);
						if (m > 3'd0) begin
							ent.act = tiep_pkg::ACT_PFX;
							ent.pfx_len = m;
							ent.has_ev = (in_byte != tiep_pkg::BYTE_ESC);
						end else begin
							ent.act = tiep_pkg::ACT_ONE;
						end
					end
				end
				default: begin
					mode_d = tiep_pkg::MODE_NORMAL;
					if (in_byte == tiep_pkg::BYTE_ESC) mode_d = tiep_pkg::MODE_ESCAPE;
					else begin
						ne = norm_ev(in_byte, nk, nc);
						ent.act = ne ? tiep_pkg::ACT_ONE : tiep_pkg::ACT_NONE;
						ent.kind = nk;
						ent.code = nc;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= tiep_pkg::MODE_NORMAL;
			pvld_q    <= '0;
			pcnt_q    <= '0;
			cur_q     <= '0;
			cur_vld_q <= 1'b0;
			sub_q     <= 1'b0;
			mouse_q   <= 1'b0;
			tmatch_q  <= '0;
			for (int i = 0; i < NP; i++) pval_q[i] <= '0;
		end else if (fire) begin
			mode_q <= mode_d;
			if (in_op) begin
				tmatch_q <= '0;
			end else if (mode_q == tiep_pkg::MODE_ESCAPE && in_byte == 8'h5b) begin
				pvld_q    <= '0;
				pcnt_q    <= '0;
				cur_q     <= '0;
				cur_vld_q <= 1'b0;
				sub_q     <= 1'b0;
				mouse_q   <= 1'b0;
			end else if (mode_q == tiep_pkg::MODE_CSI) begin
				if (!is_final && in_byte == 8'h3c) mouse_q <= 1'b1;
				else if (is_digit) begin
					if (!sub_q) begin
						cur_q     <= acc_sat;
						cur_vld_q <= 1'b1;
					end
				end else if (in_byte == 8'h3a) sub_q <= 1'b1;
				else begin
					if (int'(pcnt_q) < NP) begin
						pval_q[pcnt_q[CNT_W-1:0]] <= cur_q;
						pvld_q[pcnt_q[CNT_W-1:0]] <= cur_vld_q;
						pcnt_q <= pcnt_q + CNT_W'(1);
					end
					cur_q     <= '0;
					cur_vld_q <= 1'b0;
					sub_q     <= 1'b0;
					if (mode_d == tiep_pkg::MODE_PASTE) tmatch_q <= '0;
				end
			end else if (mode_q == tiep_pkg::MODE_PASTE) begin
				if (in_byte == tiep_pkg::term_byte((tmatch_q < 3'd6) ? tmatch_q : 3'd0))
					tmatch_q <= (mode_d == tiep_pkg::MODE_NORMAL) ? 3'd0
						: ((tmatch_q < 3'd6) ? tmatch_q : 3'd0) + 3'd1;
				else if (tmatch_q != 3'd0 && tmatch_q < 3'd6
						&& in_byte == tiep_pkg::BYTE_ESC) tmatch_q <= 3'd1;
				else tmatch_q <= '0;
			end
		end
	end

endmodule

>>> src/tiep_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tiep_queue: short action queue between front and back end
// Register-based FIFO; pushes and pops may happen in the same cycle.
// ----------------------------------------------------------------------------
module tiep_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  tiep_pkg::qent_t wdata,
	output logic            full,
	input  logic            pop,
	output tiep_pkg::qent_t rdata,
	output logic            not_empty
);

	localparam int PW = tiep_pkg::QPTR_W;

	tiep_pkg::qent_t mem_q [tiep_pkg::QDEPTH];
	logic [PW-1:0]   wp_q, rp_q;
	logic [PW:0]     cnt_q;

	assign full      = (cnt_q == (PW+1)'(tiep_pkg::QDEPTH));
	assign not_empty = (cnt_q != '0);
	assign rdata     = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + PW'(1);
			if (pop)  rp_q <= rp_q + PW'(1);
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end

	no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("queue overflow");
	no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!not_empty |-> !pop) else $error("queue underflow");
	count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + (PW+1)'(1))
		else $error("queue count");

endmodule

>>> src/tiep_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tiep_back: event sequencer
// Expands one queued action into its run of events into an output register.
// ----------------------------------------------------------------------------
module tiep_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_valid,
	input  tiep_pkg::qent_t   q_data,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [2:0]        out_kind,
	output logic [tiep_pkg::CODE_W-1:0] out_code,
	output logic [2:0]        out_mods,
	output logic [2:0]        out_mkind,
	output logic [1:0]        out_btn,
	output logic [tiep_pkg::POS_W-1:0] out_col,
	output logic [tiep_pkg::POS_W-1:0] out_row,
	output logic              out_last
);

	logic [2:0] idx_q;        // event index within the current run
	logic       ov_q;
	logic       load;
	logic       emit;
	logic       final_ev;
	logic [2:0] n_ev;         // events in this run
	tiep_pkg::qent_t e;

	assign e = q_data;

	always_comb begin
		case (e.act)
			tiep_pkg::ACT_ONE:  n_ev = 3'd1;
			tiep_pkg::ACT_ESC1: n_ev = 3'd1 + 3'(e.has_ev);
			tiep_pkg::ACT_PFX:  n_ev = e.pfx_len + 3'(e.has_ev);
			default:            n_ev = 3'd0;
		endcase
	end

	assign load     = !ov_q || out_ready;
	assign emit     = q_valid && load && (n_ev != 3'd0);
	assign final_ev = (idx_q + 3'd1 >= n_ev);
	assign q_pop    = q_valid && ((n_ev == 3'd0) || (load && final_ev));
	assign out_valid = ov_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q  <= 1'b0;
			idx_q <= '0;
		end else begin
			if (load) ov_q <= emit;
			if (emit) idx_q <= final_ev ? 3'd0 : idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_mods  <= e.mods;
			out_mkind <= e.mouse_kind;
			out_btn   <= e.mouse_button;
			out_col   <= e.col;
			out_row   <= e.row;
			out_last  <= final_ev;
			if (e.act == tiep_pkg::ACT_ESC1 && idx_q == 3'd0) begin
				out_kind <= tiep_pkg::EV_KEY;
				out_code <= tiep_pkg::K_ESC;
			end else if (e.act == tiep_pkg::ACT_PFX && idx_q < e.pfx_len) begin
				out_kind <= tiep_pkg::EV_PASTE;
				out_code <= tiep_pkg::CODE_W'(tiep_pkg::term_byte(idx_q));
			end else begin
				out_kind <= e.kind;
				out_code <= e.code;
			end
		end
	end

	stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && !out_ready) |=> ov_q && $stable(out_code) && $stable(out_last))
		else $error("output changed under stall");
	idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q < 3'd6) else $error("run index out of range");
	pop_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop && n_ev != 3'd0) |=> out_last) else $error("pop before run end");

endmodule

>>> dv/terminal_input_escape_parser_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// terminal_input_escape_parser_unit_tb: self-checking bench for the parser
// A short table of directed bytes is followed by random key, CSI, mouse and
// paste sequences. Every accepted item runs through a behavioral decoder
// here, and each event that leaves m_axis is compared with the oldest
// predicted one. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module terminal_input_escape_parser_unit_tb;

	localparam int LIMIT_CYCLES = 400000;
	localparam int RAND_ITEMS   = 200;
	localparam int DRAIN_CYCLES = 20;
	localparam logic OP_BYTE  = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	typedef struct packed {
		logic [2:0]                  kind;
		logic [tiep_pkg::CODE_W-1:0] code;
		logic [2:0]                  mods;
		logic [2:0]                  mk;
		logic [1:0]                  btn;
		logic [tiep_pkg::POS_W-1:0]  col;
		logic [tiep_pkg::POS_W-1:0]  row;
		logic                        last;
	} event_t;

	typedef struct {
		logic       op;
		logic [7:0] b;
		bit         typed;   // expected single event written in the row
		logic [2:0] kind;
		logic [tiep_pkg::CODE_W-1:0] code;
	} byte_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic        s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [79:0] m_axis_tdata;
	logic [2:0]  m_axis_tuser;
	logic        m_axis_tlast;

	terminal_input_escape_parser_unit i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	event_t    pending_events[$];
	byte_row_t byte_stream[$];
	int        err_cnt;
	int        cyc_cnt;
	bit        burst_tx, burst_rx;

	// ---------------- decoder state ----------------
	tiep_pkg::mode_t dec_mode;
	longint arg_val[tiep_pkg::MAX_PARAMS];
	bit     arg_ok[tiep_pkg::MAX_PARAMS];
	int     arg_cnt;
	longint acc_val;
	bit     acc_ok, in_sub, is_mouse;
	int     term_hits;
	event_t step_events[$];

	logic [7:0] close_seq [6] = '{tiep_pkg::BYTE_ESC, "[", "2", "0", "1", "~"};

	function automatic void put_event(logic [2:0] kind, longint code, logic [2:0] mods,
		logic [2:0] mk, logic [1:0] btn, longint col, longint row);
		event_t e;
		if (step_events.size() >= 6) return;
		e.kind = kind;
		e.code = (code > longint'(tiep_pkg::CODE_MAX)) ? tiep_pkg::CODE_MAX
			: code[tiep_pkg::CODE_W-1:0];
		e.mods = mods;
		e.mk   = mk;
		e.btn  = btn;
		e.col  = col[tiep_pkg::POS_W-1:0];
		e.row  = row[tiep_pkg::POS_W-1:0];
		e.last = 1'b0;
		step_events.insert(step_events.size(), e);
	endfunction

	function automatic void put_key(logic [2:0] kind, longint code, logic [2:0] mods);
		put_event(kind, code, mods, 3'd0, 2'd0, 0, 0);
	endfunction

	function automatic longint arg(int i, longint fallback);
		if (i >= arg_cnt || !arg_ok[i]) return fallback;
		return arg_val[i];
	endfunction

	function automatic void arg_push();
		if (arg_cnt < tiep_pkg::MAX_PARAMS) begin
			arg_val[arg_cnt] = acc_val;
			arg_ok[arg_cnt]  = acc_ok;
			arg_cnt++;
		end
		acc_val = 0;
		acc_ok  = 0;
		in_sub  = 0;
	endfunction

	function automatic void csi_reset();
		for (int i = 0; i < tiep_pkg::MAX_PARAMS; i++) begin
			arg_val[i] = 0;
			arg_ok[i]  = 0;
		end
		arg_cnt  = 0;
		acc_val  = 0;
		acc_ok   = 0;
		in_sub   = 0;
		is_mouse = 0;
	endfunction

	function automatic void plain_byte(logic [7:0] b);
		if (b == tiep_pkg::BYTE_ESC) dec_mode = tiep_pkg::MODE_ESCAPE;
		else if (b == 8'h0a) put_key(tiep_pkg::EV_KEY, tiep_pkg::K_ENTER, 0);
		else if (b == 8'h09) put_key(tiep_pkg::EV_KEY, tiep_pkg::K_TAB, 0);
		else if (b == 8'h7f) put_key(tiep_pkg::EV_KEY, tiep_pkg::K_BKSP, 0);
		else if (b >= 8'd32 && b <= 8'd126) put_key(tiep_pkg::EV_CHAR, b, 0);
	endfunction

	function automatic void key_final(logic [7:0] b);
		longint p1, p0;
		logic [2:0] m;
		p1 = arg(1, 1);
		m  = (p1 >= 1) ? 3'((p1 - 1) & 7) : 3'd0;
		case (b)
			"A": put_key(tiep_pkg::EV_KEY, tiep_pkg::K_UP, m);
			"B": put_key(tiep_pkg::EV_KEY, tiep_pkg::K_DOWN, m);
			"C": put_key(tiep_pkg::EV_KEY, tiep_pkg::K_RIGHT, m);
			"D": put_key(tiep_pkg::EV_KEY, tiep_pkg::K_LEFT, m);
			"H": put_key(tiep_pkg::EV_KEY, tiep_pkg::K_HOME, m);
			"F": put_key(tiep_pkg::EV_KEY, tiep_pkg::K_END, m);
			"~": begin
				p0 = arg(0, 0);
				case (p0)
					2: put_key(tiep_pkg::EV_KEY, tiep_pkg::K_INSERT, m);
					3: put_key(tiep_pkg::EV_KEY, tiep_pkg::K_DELETE, m);
					4, 8: put_key(tiep_pkg::EV_KEY, tiep_pkg::K_END, m);
					5: put_key(tiep_pkg::EV_KEY, tiep_pkg::K_PGUP, m);
					6: put_key(tiep_pkg::EV_KEY, tiep_pkg::K_PGDN, m);
					7: put_key(tiep_pkg::EV_KEY, tiep_pkg::K_HOME, m);
					11, 12, 13, 14, 15:
						put_key(tiep_pkg::EV_KEY, tiep_pkg::K_F1 + p0 - 11, m);
					17, 18, 19, 20, 21:
						put_key(tiep_pkg::EV_KEY, tiep_pkg::K_F1 + 5 + p0 - 17, m);
					23, 24:
						put_key(tiep_pkg::EV_KEY, tiep_pkg::K_F1 + 10 + p0 - 23, m);
					default: ;
				endcase
			end
			"u": begin
				p0 = arg(0, -1);
				if (p0 >= 0) begin
					if (p0 == 9) put_key(tiep_pkg::EV_KEY, tiep_pkg::K_TAB, m);
					else if (p0 == 13) put_key(tiep_pkg::EV_KEY, tiep_pkg::K_ENTER, m);
					else if (p0 == 27) put_key(tiep_pkg::EV_KEY, tiep_pkg::K_ESC, m);
					else if (p0 == 127) put_key(tiep_pkg::EV_KEY, tiep_pkg::K_BKSP, m);
					else put_key(tiep_pkg::EV_CHAR, p0, m);
				end
			end
			default: ;
		endcase
	endfunction

	function automatic void mouse_final(logic [7:0] b);
		longint cb, cx, cy;
		logic [2:0] m, mk;
		logic [1:0] btn, low;
		if (b != "M" && b != "m") return;
		cb = arg(0, -1);
		cx = arg(1, -1);
		cy = arg(2, -1);
		if (cb < 0 || cx < 0 || cy < 0) return;
		if (cx > longint'(tiep_pkg::CODE_MAX)) cx = tiep_pkg::CODE_MAX;
		if (cy > longint'(tiep_pkg::CODE_MAX)) cy = tiep_pkg::CODE_MAX;
		m   = {cb[4], cb[3], cb[2]};
		low = cb[1:0];
		if (cb[6]) begin
			mk  = (low == 0) ? 3'd3 : 3'd4;
			btn = 0;
		end else begin
			btn = (low == 0) ? 2'd1 : (low == 1) ? 2'd2 : (low == 2) ? 2'd3 : 2'd0;
			mk  = cb[5] ? 3'd2 : ((b == "M") ? 3'd0 : 3'd1);
		end
		put_event(tiep_pkg::EV_MOUSE, 0, m, mk, btn, cx - 1, cy - 1);
	endfunction

	function automatic void csi_in(logic [7:0] b);
		longint v;
		if (b == "<" && arg_cnt == 0 && !acc_ok && !in_sub) begin
			is_mouse = 1;
			return;
		end
		if (b >= "0" && b <= "9") begin
			if (!in_sub) begin
				v = (acc_ok ? acc_val * 10 : 0) + (b - "0");
				acc_val = (v > longint'(tiep_pkg::PARAM_MAX))
					? longint'(tiep_pkg::PARAM_MAX) : v;
				acc_ok  = 1;
			end
			return;
		end
		if (b == ":") begin in_sub = 1; return; end
		if (b == ";") begin arg_push(); return; end
		arg_push();
		dec_mode = tiep_pkg::MODE_NORMAL;
		if (b == "~" && !is_mouse && arg(0, 0) == tiep_pkg::PASTE_OPEN) begin
			dec_mode  = tiep_pkg::MODE_PASTE;
			term_hits = 0;
			return;
		end
		if (is_mouse) mouse_final(b);
		else key_final(b);
	endfunction

	function automatic void paste_in(logic [7:0] b);
		int m;
		m = (term_hits < 6) ? term_hits : 0;
		if (b == close_seq[m]) begin
			m++;
			if (m == 6) begin
				dec_mode  = tiep_pkg::MODE_NORMAL;
				term_hits = 0;
				put_key(tiep_pkg::EV_PASTE_END, 0, 0);
				return;
			end
			term_hits = m;
			return;
		end
		term_hits = 0;
		if (m > 0) begin
			// matched part of the terminator was text after all
			for (int k = 0; k < m; k++) put_key(tiep_pkg::EV_PASTE, close_seq[k], 0);
			if (b == tiep_pkg::BYTE_ESC) begin term_hits = 1; return; end
		end
		put_key(tiep_pkg::EV_PASTE, b, 0);
	endfunction

	// decode one accepted item and queue the events it produces
	function automatic void decode_item(logic op, logic [7:0] b);
		step_events.delete();
		if (op == OP_FLUSH) begin
			if (dec_mode == tiep_pkg::MODE_ESCAPE || dec_mode == tiep_pkg::MODE_SS3)
				put_key(tiep_pkg::EV_KEY, tiep_pkg::K_ESC, 0);
			dec_mode  = tiep_pkg::MODE_NORMAL;
			term_hits = 0;
		end else begin
			case (dec_mode)
				tiep_pkg::MODE_ESCAPE: begin
					dec_mode = tiep_pkg::MODE_NORMAL;
					if (b == "[") begin
						dec_mode = tiep_pkg::MODE_CSI;
						csi_reset();
					end else if (b == "O") dec_mode = tiep_pkg::MODE_SS3;
					else begin
						put_key(tiep_pkg::EV_KEY, tiep_pkg::K_ESC, 0);
						plain_byte(b);
					end
				end
				tiep_pkg::MODE_SS3: begin
					dec_mode = tiep_pkg::MODE_NORMAL;
					if (b >= "P" && b <= "S")
						put_key(tiep_pkg::EV_KEY, tiep_pkg::K_F1 + b - "P", 0);
				end
				tiep_pkg::MODE_CSI:   csi_in(b);
				tiep_pkg::MODE_PASTE: paste_in(b);
				default: begin
					dec_mode = tiep_pkg::MODE_NORMAL;
					plain_byte(b);
				end
			endcase
		end
		if (step_events.size() > 0) step_events[step_events.size()-1].last = 1'b1;
	endfunction

	// ---------------- stimulus building ----------------
	function automatic void add_byte(logic [7:0] b);
		byte_row_t r;
		r.op = OP_BYTE; r.b = b; r.typed = 0; r.kind = 0; r.code = 0;
		byte_stream.insert(byte_stream.size(), r);
	endfunction

	function automatic void add_flush();
		byte_row_t r;
		r.op = OP_FLUSH; r.b = 8'($urandom); r.typed = 0; r.kind = 0; r.code = 0;
		byte_stream.insert(byte_stream.size(), r);
	endfunction

	function automatic void add_number(longint unsigned v);
		string s;
		s = $sformatf("%0d", v);
		for (int i = 0; i < s.len(); i++) add_byte(s[i]);
	endfunction

	// small values mostly, sometimes far past the saturation point
	function automatic longint unsigned pick_number();
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: return 2097151 + $urandom_range(0, 2);
			2: return 0;
			default: return $urandom_range(1, 30);
		endcase
	endfunction

	function automatic void add_csi(bit mouse, int nargs, logic [7:0] fin);
		add_byte(tiep_pkg::BYTE_ESC);
		add_byte("[");
		if (mouse) add_byte("<");
		for (int i = 0; i < nargs; i++) begin
			if (i > 0) add_byte(";");
			if ($urandom_range(0, 7) != 0) add_number(pick_number());
			if ($urandom_range(0, 7) == 0) begin
				add_byte(":");
				add_number($urandom_range(0, 99));
			end
		end
		add_byte(fin);
	endfunction

	function automatic void add_paste();
		int n;
		add_byte(tiep_pkg::BYTE_ESC);
		add_byte("[");
		add_number(tiep_pkg::PASTE_OPEN);
		add_byte("~");
		n = $urandom_range(0, 8);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 3) == 0) begin
				// a false start of the terminator
				int k;
				k = $urandom_range(1, 5);
				for (int j = 0; j < k; j++) add_byte(close_seq[j]);
			end else add_byte(8'($urandom));
		end
		if ($urandom_range(0, 7) == 0) add_flush();
		else for (int j = 0; j < 6; j++) add_byte(close_seq[j]);
	endfunction

	function automatic void add_random_sequence();
		logic [7:0] finals [10] = '{"A", "B", "C", "D", "H", "F", "~", "u", "M", "m"};
		logic [7:0] fin;
		fin = ($urandom_range(0, 9) == 0) ? 8'($urandom) : finals[$urandom_range(0, 9)];
		case ($urandom_range(0, 11))
			0, 1: add_byte(8'($urandom_range(32, 126)));
			2: add_byte(8'($urandom));
			3: begin add_byte(tiep_pkg::BYTE_ESC); add_byte(8'($urandom)); end
			4: begin
				add_byte(tiep_pkg::BYTE_ESC);
				add_byte("O");
				add_byte(8'($urandom_range(8'h4e, 8'h54)));
			end
			5: begin
				add_byte(tiep_pkg::BYTE_ESC);
				if ($urandom_range(0, 1)) add_byte("O");
				add_flush();
			end
			6, 7: add_csi(0, $urandom_range(0, 4), fin);
			8, 9: add_csi(1, $urandom_range(2, 4), ($urandom_range(0, 1)) ? "M" : "m");
			10: add_paste();
			default: begin
				add_csi(0, $urandom_range(0, 2), fin);
				if ($urandom_range(0, 1)) add_flush();
			end
		endcase
	endfunction

	// directed part: typed rows carry the one event they must produce
	byte_row_t directed_rows [] = '{
		'{OP_BYTE,  8'h20,    1, tiep_pkg::EV_CHAR, 21'd32},
		'{OP_BYTE,  8'h7e,    1, tiep_pkg::EV_CHAR, 21'd126},
		'{OP_BYTE,  8'h0a,    1, tiep_pkg::EV_KEY,  tiep_pkg::K_ENTER},
		'{OP_BYTE,  8'h09,    1, tiep_pkg::EV_KEY,  tiep_pkg::K_TAB},
		'{OP_BYTE,  8'h7f,    1, tiep_pkg::EV_KEY,  tiep_pkg::K_BKSP},
		'{OP_BYTE,  8'h80,    0, tiep_pkg::EV_CHAR, 21'd0},
		'{OP_BYTE,  8'hff,    0, tiep_pkg::EV_CHAR, 21'd0},
		'{OP_BYTE,  8'h00,    0, tiep_pkg::EV_CHAR, 21'd0},
		'{OP_BYTE,  tiep_pkg::BYTE_ESC, 0, tiep_pkg::EV_CHAR, 21'd0},
		'{OP_FLUSH, 8'h00,    1, tiep_pkg::EV_KEY,  tiep_pkg::K_ESC},
		'{OP_BYTE,  tiep_pkg::BYTE_ESC, 0, tiep_pkg::EV_CHAR, 21'd0},
		'{OP_BYTE,  "x",      0, tiep_pkg::EV_CHAR, 21'd0},
		'{OP_BYTE,  tiep_pkg::BYTE_ESC, 0, tiep_pkg::EV_CHAR, 21'd0},
		'{OP_BYTE,  "O",      0, tiep_pkg::EV_CHAR, 21'd0},
		'{OP_BYTE,  "S",      1, tiep_pkg::EV_KEY,  tiep_pkg::K_F1 + 21'd3},
		'{OP_BYTE,  tiep_pkg::BYTE_ESC, 0, tiep_pkg::EV_CHAR, 21'd0},
		'{OP_BYTE,  "[",      0, tiep_pkg::EV_CHAR, 21'd0},
		'{OP_BYTE,  "3",      0, tiep_pkg::EV_CHAR, 21'd0},
		'{OP_BYTE,  ";",      0, tiep_pkg::EV_CHAR, 21'd0},
		'{OP_BYTE,  "5",      0, tiep_pkg::EV_CHAR, 21'd0},
		'{OP_BYTE,  "~",      0, tiep_pkg::EV_CHAR, 21'd0}
	};

	// ---------------- sender ----------------
	task automatic send_item(byte_row_t r);
		int gap;
		event_t e;
		if ($urandom_range(0, 15) == 0) burst_tx = !burst_tx;
		gap = burst_tx ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= r.op;
		s_axis_tdata  <= r.b;
		do @(posedge clk); while (!s_axis_tready);
		decode_item(r.op, r.b);
		if (r.typed) begin
			e = '{r.kind, r.code, 3'd0, 3'd0, 2'd0, '0, '0, 1'b1};
			pending_events.insert(pending_events.size(), e);
		end else begin
			foreach (step_events[i])
				pending_events.insert(pending_events.size(), step_events[i]);
		end
	endtask

	initial begin
		int sent;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= 8'h00;
		s_axis_tuser  <= 1'b0;
		err_cnt   = 0;
		burst_tx  = 0;
		dec_mode  = tiep_pkg::MODE_NORMAL;
		term_hits = 0;
		csi_reset();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) send_item(directed_rows[i]);

		while (byte_stream.size() < RAND_ITEMS) add_random_sequence();
		sent = 0;
		while (byte_stream.size() > 0) begin
			if (sent == RAND_ITEMS / 2) begin
				// hold off until the output side has drained
				s_axis_tvalid <= 1'b0;
				while (pending_events.size() > 0) @(posedge clk);
				@(posedge clk);
			end
			send_item(byte_stream.pop_front());
			sent++;
		end
		s_axis_tvalid <= 1'b0;

		while (pending_events.size() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_cnt == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	// ---------------- receiver ----------------
	initial begin
		int stall;
		m_axis_tready <= 1'b0;
		burst_rx = 0;
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 15) == 0) burst_rx = !burst_rx;
			stall = burst_rx ? 0 : $urandom_range(0, 19);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	// ---------------- event checker ----------------
	always @(posedge clk) begin
		event_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.kind = m_axis_tuser;
			got.code = m_axis_tdata[20:0];
			got.mods = m_axis_tdata[23:21];
			got.mk   = m_axis_tdata[26:24];
			got.btn  = m_axis_tdata[28:27];
			got.col  = m_axis_tdata[50:29];
			got.row  = m_axis_tdata[72:51];
			got.last = m_axis_tlast;
			if (pending_events.size() == 0) begin
				err_cnt++;
				$display("%0t: unexpected event, expected none, actual %p", $realtime, got);
			end else begin
				want = pending_events.pop_front();
				if (got != want || m_axis_tdata[79:73] != 7'd0) begin
					err_cnt++;
					$display("%0t: event mismatch, expected %p, actual %p pad %h",
						$realtime, want, got, m_axis_tdata[79:73]);
				end
			end
		end
	end

	// ---------------- watchdog ----------------
	initial cyc_cnt = 0;
	always @(posedge clk) begin
		cyc_cnt <= cyc_cnt + 1;
		if (cyc_cnt > LIMIT_CYCLES) begin
			$display("Mismatches found");
			$finish;
		end
	end

endmodule

>>> sim.f
src/tiep_pkg.sv
src/tiep_front.sv
src/tiep_queue.sv
src/tiep_back.sv
src/terminal_input_escape_parser_unit.sv
dv/terminal_input_escape_parser_unit_tb.sv
